// ===== src/etdc_pkg.sv =====
// Package for the dual-channel edge-triggered capture block.
// Holds field widths, reset values, request and register codes and the status struct.
// No dependencies; used by every module under src.
package etdc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 10;
  localparam int RIDX_W   = 9;
  localparam int OP_W     = 2;
  localparam int CFG_W    = 16;

  localparam int BUFFER_DEPTH_DEF = 512;

  // Packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;

  localparam logic [SAMPLE_W-1:0] TRIG_LEVEL_RST = 16'd32768;
  localparam logic [POS_W-1:0]    CAP_LEN_RST    = 10'd402;
  localparam logic [SAMPLE_W-1:0] PEAK_HI_RST    = 16'd0;
  localparam logic [SAMPLE_W-1:0] PEAK_LO_RST    = 16'hFFFF;

  // Request kinds; code 3 is unused
  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic {
    REG_TRIGGER_LEVEL  = 1'b0,
    REG_CAPTURE_LENGTH = 1'b1
  } cfg_reg_t;

  // Status of one request, as reported in the result
  typedef struct packed {
    logic                done;
    logic                fired;
    logic                busy;
    logic [POS_W-1:0]    pos;
    logic [SAMPLE_W-1:0] ch1_hi;
    logic [SAMPLE_W-1:0] ch1_lo;
    logic [SAMPLE_W-1:0] ch2_hi;
    logic [SAMPLE_W-1:0] ch2_lo;
  } status_t;

  // Buffer write command from the capture control to the sample memory
  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] ch1;
    logic [SAMPLE_W-1:0] ch2;
  } wr_cmd_t;

endpackage

// ===== src/edge_triggered_dual_capture.sv =====
// Top level of the dual-channel edge-triggered capture block.
// Depends on etdc_pkg, etdc_capture and etdc_sample_ram.
//
// Usage:
//   in_*  : request stream. in_tuser carries the kind (start, sample, read),
//           in_tdata the arm flag, the two channel samples and the read index.
//   out_* : one result per request: done/fired/busy flags, write position,
//           running extremes of both channels and the read pair.
//   cfg_* : register writes (0 trigger level, 1 capture length), always ready;
//           write only while no request is in flight.
// A request is held in one input register, then the capture logic and the
// buffer read feed the result register.
// Throughput is one request per cycle while out_tready is high; the buffer
// has one write and one read port, and a request uses at most one of them.
// Reset clears the run, arm and position state, the extremes and the registers
// (level 32768, length 402); the buffer contents stay unknown until written.
// When out_tready is low the result holds, one more request waits in the input
// register, and in_tready drops after that.
module edge_triggered_dual_capture #(
  parameter int BUFFER_DEPTH = etdc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] arm_trigger, [16:1] ch1_sample, [32:17] ch2_sample, [41:33] read_index
  input  logic [etdc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [etdc_pkg::OP_W-1:0]        in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] capture_done, [1] trigger_fired, [2] busy_res, [12:3] write_position,
  // [28:13] ch1_peak_high, [44:29] ch1_peak_low, [60:45] ch2_peak_high,
  // [76:61] ch2_peak_low, [92:77] read_ch1, [108:93] read_ch2
  output logic [etdc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [etdc_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int RXW = (AW > etdc_pkg::RIDX_W) ? AW : etdc_pkg::RIDX_W;

  logic [etdc_pkg::SAMPLE_W-1:0] trig_level_r;
  logic [etdc_pkg::POS_W-1:0]    cap_len_r;

  logic                          s1_v_r;
  logic [etdc_pkg::OP_W-1:0]     s1_op_r;
  logic                          s1_arm_r;
  logic [etdc_pkg::SAMPLE_W-1:0] s1_ch1_r, s1_ch2_r;
  logic [etdc_pkg::RIDX_W-1:0]   s1_ridx_r;

  logic                          out_v_r;
  etdc_pkg::status_t             out_stat_r;
  logic                          out_rd_ok_r;

  logic                          adv, in_acc;
  logic                          rd_ok;
  logic [RXW-1:0]                ridx_x;
  etdc_pkg::status_t             stat_nxt;
  etdc_pkg::wr_cmd_t             wr_cmd;
  logic [AW-1:0]                 wr_addr;
  logic [etdc_pkg::SAMPLE_W-1:0] rd_ch1, rd_ch2, res_ch1, res_ch2;

  // Handshake: the input register moves on whenever the result slot frees up
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_level_r <= etdc_pkg::TRIG_LEVEL_RST;
      cap_len_r    <= etdc_pkg::CAP_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        etdc_pkg::REG_TRIGGER_LEVEL:  trig_level_r <= cfg_data;
        etdc_pkg::REG_CAPTURE_LENGTH: cap_len_r    <= cfg_data[etdc_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_tuser;
      s1_arm_r  <= in_tdata[0];
      s1_ch1_r  <= in_tdata[16:1];
      s1_ch2_r  <= in_tdata[32:17];
      s1_ridx_r <= in_tdata[41:33];
    end
  end

  etdc_capture #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv),
    .op             (s1_op_r),
    .arm            (s1_arm_r),
    .ch1            (s1_ch1_r),
    .ch2            (s1_ch2_r),
    .trigger_level  (trig_level_r),
    .capture_length (cap_len_r),
    .status_nxt     (stat_nxt),
    .wr_cmd         (wr_cmd),
    .wr_addr        (wr_addr)
  );

  // Read decode; indexes past the buffer read as zero
  assign ridx_x = RXW'(s1_ridx_r);
  assign rd_ok  = (s1_op_r == etdc_pkg::OP_READ) &&
                  (32'(s1_ridx_r) < 32'(BUFFER_DEPTH));

  etdc_sample_ram #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_ram (
    .clk     (clk),
    .wr_cmd  (wr_cmd),
    .wr_addr (wr_addr),
    .rd_en   (adv && rd_ok),
    .rd_addr (ridx_x[AW-1:0]),
    .rd_ch1  (rd_ch1),
    .rd_ch2  (rd_ch2)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stat_r  <= stat_nxt;
      out_rd_ok_r <= rd_ok;
    end
  end

  assign res_ch1 = out_rd_ok_r ? rd_ch1 : '0;
  assign res_ch2 = out_rd_ok_r ? rd_ch2 : '0;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, res_ch2, res_ch1,
                       out_stat_r.ch2_lo, out_stat_r.ch2_hi,
                       out_stat_r.ch1_lo, out_stat_r.ch1_hi,
                       out_stat_r.pos, out_stat_r.busy,
                       out_stat_r.fired, out_stat_r.done};

`ifndef SYNTHESIS
  // A held request must stall the input side while the result is blocked
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while the pipeline is full");

  // A request never both writes and reads the buffer
  a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rd_ok) |-> !wr_cmd.en)
    else $error("buffer read and write in the same cycle");

  // Finishing a capture always ends the run
  a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stat_r.done) |-> !out_stat_r.busy)
    else $error("capture done reported while still busy");

  // A trigger restarts the capture at position one
  a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stat_r.fired) |-> (out_stat_r.pos == etdc_pkg::POS_W'(1)))
    else $error("trigger did not restart the write position");

  // A new result only appears after a request moved out of the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(adv))
    else $error("result valid without a request");
`endif

endmodule

// ===== src/etdc_sample_ram.sv =====
// Sample memory: two channel arrays, one write port and one registered read port.
// Depends on etdc_pkg for the sample width and the write command struct.
module etdc_sample_ram #(
  parameter int BUFFER_DEPTH = etdc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                          clk,
  input  etdc_pkg::wr_cmd_t             wr_cmd,
  input  logic [AW-1:0]                 wr_addr,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [etdc_pkg::SAMPLE_W-1:0] rd_ch1,
  output logic [etdc_pkg::SAMPLE_W-1:0] rd_ch2
);

  logic [etdc_pkg::SAMPLE_W-1:0] ch1_mem [BUFFER_DEPTH];
  logic [etdc_pkg::SAMPLE_W-1:0] ch2_mem [BUFFER_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_cmd.en) begin
      ch1_mem[wr_addr] <= wr_cmd.ch1;
      ch2_mem[wr_addr] <= wr_cmd.ch2;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ch1 <= ch1_mem[rd_addr];
      rd_ch2 <= ch2_mem[rd_addr];
    end
  end

endmodule

// ===== src/etdc_capture.sv =====
// Capture control: run/arm state, write position, trigger detect and running extremes.
// Depends on etdc_pkg; drives the write side of etdc_sample_ram.
module etdc_capture #(
  parameter int BUFFER_DEPTH = etdc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [etdc_pkg::OP_W-1:0]     op,
  input  logic                          arm,
  input  logic [etdc_pkg::SAMPLE_W-1:0] ch1,
  input  logic [etdc_pkg::SAMPLE_W-1:0] ch2,
  input  logic [etdc_pkg::SAMPLE_W-1:0] trigger_level,
  input  logic [etdc_pkg::POS_W-1:0]    capture_length,
  output etdc_pkg::status_t             status_nxt,
  output etdc_pkg::wr_cmd_t             wr_cmd,
  output logic [AW-1:0]                 wr_addr
);

  localparam int XW = (AW > etdc_pkg::POS_W) ? AW : etdc_pkg::POS_W;

  logic [etdc_pkg::POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  logic                          armed_r, armed_nxt;
  logic                          running_r, running_nxt;
  logic [etdc_pkg::SAMPLE_W-1:0] prev_ch1_r, prev_ch1_nxt;
  logic                          prev_valid_r, prev_valid_nxt;
  logic [etdc_pkg::SAMPLE_W-1:0] ch1_hi_r, ch1_hi_nxt, ch1_lo_r, ch1_lo_nxt;
  logic [etdc_pkg::SAMPLE_W-1:0] ch2_hi_r, ch2_hi_nxt, ch2_lo_r, ch2_lo_nxt;
  logic [31:0]                   limit;
  logic [XW-1:0]                 pos_x;
  logic                          fire, done;

  // Capture length clamped to the buffer depth
  assign limit = (32'(capture_length) > 32'(BUFFER_DEPTH)) ? 32'(BUFFER_DEPTH)
                                                           : 32'(capture_length);

  // Rising edge on channel 1 through the level
  assign fire = armed_r && (ch1 > trigger_level) && prev_valid_r &&
                (prev_ch1_r < trigger_level);

  assign pos_inc = fire ? etdc_pkg::POS_W'(1) : pos_r + etdc_pkg::POS_W'(1);

  // Next state for one request
  always_comb begin
    pos_nxt        = pos_r;
    armed_nxt      = armed_r;
    running_nxt    = running_r;
    prev_ch1_nxt   = prev_ch1_r;
    prev_valid_nxt = prev_valid_r;
    ch1_hi_nxt     = ch1_hi_r;
    ch1_lo_nxt     = ch1_lo_r;
    ch2_hi_nxt     = ch2_hi_r;
    ch2_lo_nxt     = ch2_lo_r;
    done           = 1'b0;
    case (op)
      etdc_pkg::OP_START: begin
        pos_nxt        = '0;
        armed_nxt      = arm;
        running_nxt    = 1'b1;
        prev_valid_nxt = 1'b0;
        ch1_hi_nxt     = etdc_pkg::PEAK_HI_RST;
        ch1_lo_nxt     = etdc_pkg::PEAK_LO_RST;
        ch2_hi_nxt     = etdc_pkg::PEAK_HI_RST;
        ch2_lo_nxt     = etdc_pkg::PEAK_LO_RST;
      end
      etdc_pkg::OP_SAMPLE: begin
        if (running_r) begin
          prev_ch1_nxt   = ch1;
          prev_valid_nxt = 1'b1;
          pos_nxt        = pos_inc;
          if (fire) begin
            armed_nxt  = 1'b0;
            ch1_hi_nxt = etdc_pkg::PEAK_HI_RST;
            ch1_lo_nxt = etdc_pkg::PEAK_LO_RST;
            ch2_hi_nxt = etdc_pkg::PEAK_HI_RST;
            ch2_lo_nxt = etdc_pkg::PEAK_LO_RST;
          end else begin
            ch1_hi_nxt = (ch1 > ch1_hi_r) ? ch1 : ch1_hi_r;
            ch1_lo_nxt = (ch1 < ch1_lo_r) ? ch1 : ch1_lo_r;
            ch2_hi_nxt = (ch2 > ch2_hi_r) ? ch2 : ch2_hi_r;
            ch2_lo_nxt = (ch2 < ch2_lo_r) ? ch2 : ch2_lo_r;
          end
          if (32'(pos_inc) >= limit) begin
            running_nxt = 1'b0;
            done        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result status
  always_comb begin
    status_nxt.done   = done;
    status_nxt.fired  = (op == etdc_pkg::OP_SAMPLE) && running_r && fire;
    status_nxt.busy   = running_nxt;
    status_nxt.pos    = pos_nxt;
    status_nxt.ch1_hi = ch1_hi_nxt;
    status_nxt.ch1_lo = ch1_lo_nxt;
    status_nxt.ch2_hi = ch2_hi_nxt;
    status_nxt.ch2_lo = ch2_lo_nxt;
  end

  // Buffer write at the current position
  assign pos_x      = XW'(pos_r);
  assign wr_addr    = pos_x[AW-1:0];
  assign wr_cmd.en  = step && (op == etdc_pkg::OP_SAMPLE) && running_r &&
                      (32'(pos_r) < 32'(BUFFER_DEPTH));
  assign wr_cmd.ch1 = ch1;
  assign wr_cmd.ch2 = ch2;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      armed_r      <= 1'b0;
      running_r    <= 1'b0;
      prev_ch1_r   <= '0;
      prev_valid_r <= 1'b0;
      ch1_hi_r     <= etdc_pkg::PEAK_HI_RST;
      ch1_lo_r     <= etdc_pkg::PEAK_LO_RST;
      ch2_hi_r     <= etdc_pkg::PEAK_HI_RST;
      ch2_lo_r     <= etdc_pkg::PEAK_LO_RST;
    end else if (step) begin
      pos_r        <= pos_nxt;
      armed_r      <= armed_nxt;
      running_r    <= running_nxt;
      prev_ch1_r   <= prev_ch1_nxt;
      prev_valid_r <= prev_valid_nxt;
      ch1_hi_r     <= ch1_hi_nxt;
      ch1_lo_r     <= ch1_lo_nxt;
      ch2_hi_r     <= ch2_hi_nxt;
      ch2_lo_r     <= ch2_lo_nxt;
    end
  end

endmodule
